// File: rtl/core/tbrp_pkg.sv
// ----------------------------------------------------------------------------
// Tagged binary record parser package
// Shared result and stack-control types, item kinds and error codes.
// ----------------------------------------------------------------------------
package tbrp_pkg;

  localparam int MAX_DEPTH_DEF = 64;
  localparam int MAX_NAMES_DEF = 4096;

  // Item kinds on the result channel
  localparam logic [3:0] KIND_END     = 4'd0;
  localparam logic [3:0] KIND_OBJECT  = 4'd1;
  localparam logic [3:0] KIND_ARRAY   = 4'd2;
  localparam logic [3:0] KIND_NULL    = 4'd3;
  localparam logic [3:0] KIND_BOOL    = 4'd4;
  localparam logic [3:0] KIND_UINT    = 4'd5;
  localparam logic [3:0] KIND_SINT    = 4'd6;
  localparam logic [3:0] KIND_FP32    = 4'd7;
  localparam logic [3:0] KIND_FP64    = 4'd8;
  localparam logic [3:0] KIND_STRING  = 4'd9;
  localparam logic [3:0] KIND_BINARY  = 4'd10;
  localparam logic [3:0] KIND_PAYLOAD = 4'd11;
  localparam logic [3:0] KIND_NAME    = 4'd12;
  localparam logic [3:0] KIND_ERROR   = 4'd13;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OVERLONG  = 3'd1;
  localparam logic [2:0] ERR_BAD_INDEX = 3'd2;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd3;
  localparam logic [2:0] ERR_BAD_FLAG  = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd5;
  localparam logic [2:0] ERR_TOO_BIG   = 3'd6;

  typedef struct packed {
    logic push;
    logic pop;
    logic push_obj;
  } stack_ctrl_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        has_name;
    logic [11:0] name_ref;
    logic [6:0]  nest_depth;
    logic        run_last;
    logic [2:0]  error_code;
  } result_t;

endpackage

// File: rtl/core/tbrp_scope_stack.sv
// ----------------------------------------------------------------------------
// Scope stack
// Holds the kind of every open scope. The top entry and the one below it sit
// in registers; deeper entries live in a memory with a registered read port.
// ----------------------------------------------------------------------------
module tbrp_scope_stack
  import tbrp_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  stack_ctrl_t                        ctrl,
  output logic [$clog2(MAX_DEPTH + 1) - 1:0] depth,
  output logic                               in_obj
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic               mem [MAX_DEPTH];
  logic               top_obj;
  logic               below_obj;
  logic [DEPTH_W-1:0] depth_next;
  logic [DEPTH_W-1:0] wr_full;
  logic [DEPTH_W-1:0] rd_full;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic               do_push;
  logic               do_pop;

  assign do_push = step && ctrl.push;
  assign do_pop  = step && ctrl.pop;

  always_comb begin
    depth_next = depth;
    if (do_push) begin
      depth_next = depth + DEPTH_W'(1);
    end else if (do_pop) begin
      depth_next = depth - DEPTH_W'(1);
    end
  end

  // The memory holds every entry under the top one. The read port always
  // follows the entry just below the top after this beat.
  assign wr_full = depth - DEPTH_W'(1);
  assign rd_full = depth_next - DEPTH_W'(2);
  assign wr_addr = wr_full[ADDR_W-1:0];
  assign rd_addr = (depth_next >= DEPTH_W'(2)) ? rd_full[ADDR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (do_push && depth != '0) begin
      mem[wr_addr] <= top_obj;
    end
    // A push writes the address that is read next, so forward the old top.
    if (do_push) begin
      below_obj <= top_obj;
    end else begin
      below_obj <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      top_obj <= 1'b0;
    end else begin
      depth <= depth_next;
      if (do_push) begin
        top_obj <= ctrl.push_obj;
      end else if (do_pop) begin
        top_obj <= below_obj;
      end
    end
  end

  assign in_obj = (depth != '0) && top_obj;

endmodule

// File: rtl/core/tbrp_parser.sv
// ----------------------------------------------------------------------------
// Parser step
// Decodes one stream byte against the parse state and gives at most one
// result per byte. Holds the phase, accumulator, counters and name state.
// ----------------------------------------------------------------------------
module tbrp_parser
  import tbrp_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int MAX_NAMES = MAX_NAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [7:0]                         in_byte,
  input  logic [$clog2(MAX_DEPTH + 1) - 1:0] depth,
  input  logic                               in_obj,
  output stack_ctrl_t                        stk,
  output logic                               res_vld,
  output result_t                            res
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int NAME_W  = $clog2(MAX_NAMES + 1);

  localparam int VLQ_GROUP_BITS = 7;
  localparam int VLQ_LAST_GROUP = 9;
  localparam int VLQ_MORE_BIT   = 7;

  localparam int F_NUMBER  = 0;
  localparam int F_NAMED   = 1;
  localparam int F_INDEXED = 2;
  localparam int F_NEG     = 3;  // negative integer, or null when not a number
  localparam int F_FP32    = 4;  // fp32, or binary when not a number
  localparam int F_FP64    = 5;  // fp64, or string when not a number
  localparam int F_TRUE    = 6;  // true, or object when not a number
  localparam int F_FALSE   = 7;  // false, or array when not a number

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_NAME_IDX,
    PH_NAME_LEN,
    PH_NAME_BYTES,
    PH_INT,
    PH_FP,
    PH_LEN,
    PH_PAYLOAD
  } phase_t;

  function automatic logic has_body(input logic [7:0] f);
    logic r;
    if (!f[F_NUMBER] && (f[F_TRUE] || f[F_FALSE])) begin
      r = 1'b0;
    end else if (f[F_NUMBER]) begin
      r = !(f[F_TRUE] || f[F_FALSE]);
    end else begin
      r = f[F_FP32] || f[F_FP64];
    end
    return r;
  endfunction

  phase_t            phase;
  logic [7:0]        held_flag;
  logic [63:0]       acc;
  logic [3:0]        grp;
  logic [31:0]       bytes_left;
  logic [NAME_W-1:0] names_seen;
  logic [NAME_W-1:0] current_name;
  logic              name_valid;
  logic              failed;

  phase_t            phase_next;
  logic [7:0]        held_flag_next;
  logic [63:0]       acc_next;
  logic [3:0]        grp_next;
  logic [31:0]       bytes_left_next;
  logic [NAME_W-1:0] names_seen_next;
  logic [NAME_W-1:0] current_name_next;
  logic              name_valid_next;
  logic              failed_next;

  // Shared datapath pieces
  logic [6:0]  vlq_shamt;
  logic [63:0] vlq_acc;
  logic        vlq_over;
  logic        vlq_done;
  logic [63:0] fp_acc;
  logic [31:0] bl_dec;
  logic        idx_bad;

  assign vlq_shamt = 7'(grp * VLQ_GROUP_BITS);
  assign vlq_acc   = acc | ({57'b0, in_byte[6:0]} << vlq_shamt);
  assign vlq_over  = in_byte[VLQ_MORE_BIT] && (grp == 4'(VLQ_LAST_GROUP));
  assign vlq_done  = !in_byte[VLQ_MORE_BIT];
  assign fp_acc    = acc | ({56'b0, in_byte} << {grp[2:0], 3'b000});
  assign bl_dec    = bytes_left - 32'd1;
  assign idx_bad   = (|vlq_acc[63:NAME_W]) || (vlq_acc[NAME_W-1:0] >= names_seen);

  // Start of an item once its flag (and any name head) is known
  logic [7:0] fsel;
  logic       bi_emit;
  logic [3:0] bi_kind;
  logic       bi_bool;
  logic       bi_fail;
  logic [2:0] bi_err;
  logic       bi_push;
  logic       bi_pop;
  logic       bi_vlq_reset;
  logic       bi_load_fp;
  phase_t     bi_phase;

  assign fsel = (phase == PH_FLAG) ? in_byte : held_flag;

  always_comb begin
    bi_emit      = 1'b0;
    bi_kind      = KIND_END;
    bi_bool      = 1'b0;
    bi_fail      = 1'b0;
    bi_err       = ERR_NONE;
    bi_push      = 1'b0;
    bi_pop       = 1'b0;
    bi_vlq_reset = 1'b0;
    bi_load_fp   = 1'b0;
    bi_phase     = PH_FLAG;
    priority if (fsel == 8'd0) begin
      if (depth == '0) begin
        bi_fail = 1'b1;
        bi_err  = ERR_UNDERFLOW;
      end else begin
        bi_pop  = 1'b1;
        bi_emit = 1'b1;
        bi_kind = KIND_END;
      end
    end else if (!fsel[F_NUMBER] && (fsel[F_TRUE] || fsel[F_FALSE])) begin
      if (depth >= DEPTH_W'(MAX_DEPTH)) begin
        bi_fail = 1'b1;
        bi_err  = ERR_OVERFLOW;
      end else begin
        bi_push = 1'b1;
        bi_emit = 1'b1;
        bi_kind = fsel[F_TRUE] ? KIND_OBJECT : KIND_ARRAY;
      end
    end else if (fsel[F_NUMBER]) begin
      if (fsel[F_TRUE] || fsel[F_FALSE]) begin
        bi_emit = 1'b1;
        bi_kind = KIND_BOOL;
        bi_bool = fsel[F_TRUE];
      end else if (fsel[F_FP32] || fsel[F_FP64]) begin
        bi_vlq_reset = 1'b1;
        bi_load_fp   = 1'b1;
        bi_phase     = PH_FP;
      end else begin
        bi_vlq_reset = 1'b1;
        bi_phase     = PH_INT;
      end
    end else if (fsel[F_FP32] || fsel[F_FP64]) begin
      bi_vlq_reset = 1'b1;
      bi_phase     = PH_LEN;
    end else if (fsel[F_NEG]) begin
      bi_emit = 1'b1;
      bi_kind = KIND_NULL;
    end else begin
      bi_fail = 1'b1;
      bi_err  = ERR_BAD_FLAG;
    end
  end

  logic               use_bi;
  logic               to_name_bytes;
  logic               emit;
  logic [3:0]         r_kind;
  logic [63:0]        r_value;
  logic               r_last;
  logic [2:0]         r_err;
  logic [DEPTH_W-1:0] depth_next;
  logic [DEPTH_W+6:0] depth_ext;
  logic [NAME_W+11:0] name_ext;

  always_comb begin
    phase_next        = phase;
    held_flag_next    = held_flag;
    acc_next          = acc;
    grp_next          = grp;
    bytes_left_next   = bytes_left;
    names_seen_next   = names_seen;
    current_name_next = current_name;
    name_valid_next   = name_valid;
    failed_next       = failed;
    use_bi            = 1'b0;
    to_name_bytes     = 1'b0;
    emit              = 1'b0;
    r_kind            = KIND_END;
    r_value           = '0;
    r_last            = 1'b0;
    r_err             = ERR_NONE;
    stk               = '0;

    if (!failed) begin
      unique case (phase)
        PH_FLAG: begin
          held_flag_next  = in_byte;
          name_valid_next = 1'b0;
          if (in_byte[F_NAMED] && in_obj) begin
            acc_next   = '0;
            grp_next   = '0;
            phase_next = in_byte[F_INDEXED] ? PH_NAME_IDX : PH_NAME_LEN;
          end else begin
            use_bi = 1'b1;
          end
        end
        PH_NAME_IDX: begin
          acc_next = vlq_acc;
          grp_next = grp + 4'd1;
          if (vlq_over) begin
            emit  = 1'b1;
            r_err = ERR_OVERLONG;
          end else if (vlq_done) begin
            if (idx_bad) begin
              emit  = 1'b1;
              r_err = ERR_BAD_INDEX;
            end else begin
              current_name_next = vlq_acc[NAME_W-1:0];
              name_valid_next   = 1'b1;
              use_bi            = 1'b1;
            end
          end
        end
        PH_NAME_LEN: begin
          acc_next = vlq_acc;
          grp_next = grp + 4'd1;
          if (vlq_over) begin
            emit  = 1'b1;
            r_err = ERR_OVERLONG;
          end else if (vlq_done) begin
            if (|vlq_acc[63:32]) begin
              emit  = 1'b1;
              r_err = ERR_TOO_BIG;
            end else if (names_seen >= NAME_W'(MAX_NAMES)) begin
              emit  = 1'b1;
              r_err = ERR_OVERFLOW;
            end else begin
              current_name_next = names_seen;
              names_seen_next   = names_seen + NAME_W'(1);
              name_valid_next   = 1'b1;
              bytes_left_next   = vlq_acc[31:0];
              if (vlq_acc[31:0] == 32'd0) begin
                use_bi = 1'b1;
              end else if (!has_body(held_flag)) begin
                // Item without a body is reported before its name bytes.
                use_bi        = 1'b1;
                to_name_bytes = 1'b1;
              end else begin
                phase_next = PH_NAME_BYTES;
              end
            end
          end
        end
        PH_NAME_BYTES: begin
          bytes_left_next = bl_dec;
          emit            = 1'b1;
          r_kind          = KIND_NAME;
          r_value         = {56'b0, in_byte};
          r_last          = (bl_dec == 32'd0);
          if (bl_dec == 32'd0) begin
            if (has_body(held_flag)) begin
              use_bi = 1'b1;
            end else begin
              phase_next = PH_FLAG;
            end
          end
        end
        PH_INT: begin
          acc_next = vlq_acc;
          grp_next = grp + 4'd1;
          if (vlq_over) begin
            emit  = 1'b1;
            r_err = ERR_OVERLONG;
          end else if (vlq_done) begin
            phase_next = PH_FLAG;
            emit       = 1'b1;
            if (held_flag[F_NEG]) begin
              r_kind  = KIND_SINT;
              r_value = 64'd0 - vlq_acc;
            end else begin
              r_kind  = KIND_UINT;
              r_value = vlq_acc;
            end
          end
        end
        PH_FP: begin
          acc_next        = fp_acc;
          grp_next        = grp + 4'd1;
          bytes_left_next = bl_dec;
          if (bl_dec == 32'd0) begin
            phase_next = PH_FLAG;
            emit       = 1'b1;
            r_kind     = held_flag[F_FP32] ? KIND_FP32 : KIND_FP64;
            r_value    = fp_acc;
          end
        end
        PH_LEN: begin
          acc_next = vlq_acc;
          grp_next = grp + 4'd1;
          if (vlq_over) begin
            emit  = 1'b1;
            r_err = ERR_OVERLONG;
          end else if (vlq_done) begin
            if (|vlq_acc[63:32]) begin
              emit  = 1'b1;
              r_err = ERR_TOO_BIG;
            end else begin
              bytes_left_next = vlq_acc[31:0];
              phase_next      = (vlq_acc[31:0] != 32'd0) ? PH_PAYLOAD : PH_FLAG;
              emit            = 1'b1;
              r_kind          = held_flag[F_FP32] ? KIND_BINARY : KIND_STRING;
              r_value         = vlq_acc;
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_left_next = bl_dec;
          if (bl_dec == 32'd0) begin
            phase_next = PH_FLAG;
          end
          emit    = 1'b1;
          r_kind  = KIND_PAYLOAD;
          r_value = {56'b0, in_byte};
          r_last  = (bl_dec == 32'd0);
        end
      endcase

      // Any error code raised above is a fault
      if (emit && r_err != ERR_NONE) begin
        r_kind          = KIND_ERROR;
        r_value         = '0;
        failed_next     = 1'b1;
        name_valid_next = 1'b0;
      end

      if (use_bi) begin
        phase_next = bi_phase;
        if (bi_vlq_reset) begin
          acc_next = '0;
          grp_next = '0;
        end
        if (bi_load_fp) begin
          bytes_left_next = fsel[F_FP32] ? 32'd4 : 32'd8;
        end
        stk.push     = bi_push;
        stk.pop      = bi_pop;
        stk.push_obj = fsel[F_TRUE];
        if (bi_pop) begin
          name_valid_next = 1'b0;
        end
        if (bi_fail) begin
          failed_next     = 1'b1;
          name_valid_next = 1'b0;
          emit            = 1'b1;
          r_kind          = KIND_ERROR;
          r_value         = '0;
          r_err           = bi_err;
        end else if (bi_emit && !emit) begin
          emit    = 1'b1;
          r_kind  = bi_kind;
          r_value = {63'b0, bi_bool};
        end
        if (to_name_bytes && !bi_fail) begin
          phase_next = PH_NAME_BYTES;
        end
      end
    end
  end

  always_comb begin
    depth_next = depth;
    if (stk.push) begin
      depth_next = depth + DEPTH_W'(1);
    end else if (stk.pop) begin
      depth_next = depth - DEPTH_W'(1);
    end
  end

  assign depth_ext = {7'b0, depth_next};
  assign name_ext  = {12'b0, current_name_next};

  assign res_vld        = emit;
  assign res.kind       = r_kind;
  assign res.value      = r_value;
  assign res.has_name   = name_valid_next;
  assign res.name_ref   = name_valid_next ? name_ext[11:0] : 12'd0;
  assign res.nest_depth = depth_ext[6:0];
  assign res.run_last   = r_last;
  assign res.error_code = r_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FLAG;
      held_flag    <= '0;
      acc          <= '0;
      grp          <= '0;
      bytes_left   <= '0;
      names_seen   <= '0;
      current_name <= '0;
      name_valid   <= 1'b0;
      failed       <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      held_flag    <= held_flag_next;
      acc          <= acc_next;
      grp          <= grp_next;
      bytes_left   <= bytes_left_next;
      names_seen   <= names_seen_next;
      current_name <= current_name_next;
      name_valid   <= name_valid_next;
      failed       <= failed_next;
    end
  end

endmodule

// File: rtl/core/tagged_binary_record_parser.sv
// ----------------------------------------------------------------------------
// Tagged binary record parser
// Parses a serialized tagged record stream, one byte per beat, into items.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one stream byte per beat on in_byte.
// Output channel: out_valid/out_ready carry one parsed item per beat: kind,
// value, has_name, name_ref, nest_depth, run_last and error_code.
// A byte gives at most one item; many bytes (length and integer groups,
// float bytes, name heads) give none.
// A byte lands in an input register when it is accepted and is parsed from
// there; the item of the byte that completes it is captured in the output
// register and offered from there. A stall can hold either register.
// Throughput: one byte per cycle unless the receiver stalls the output
// register, which the parse step feeds; scope pushes and pops never stall.
// Reset clears the parse state, the name count and the scope depth. A
// malformed stream gives one error item and then every further byte is
// swallowed without a result until the next reset.
// When the receiver stalls, the output register holds its item and the
// input register holds one more byte; in_ready then falls until the
// output beat completes.
// ----------------------------------------------------------------------------
module tagged_binary_record_parser
  import tbrp_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int MAX_NAMES = MAX_NAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [63:0] value,
  output logic        has_name,
  output logic [11:0] name_ref,
  output logic [6:0]  nest_depth,
  output logic        run_last,
  output logic [2:0]  error_code
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  logic               byte_vld;
  logic [7:0]         byte_q;
  logic               step;
  stack_ctrl_t        stk;
  logic [DEPTH_W-1:0] depth;
  logic               in_obj;
  logic               res_vld;
  result_t            res;
  result_t            out_q;

  // The parse step advances whenever a byte is held and the output register is free this cycle.
  assign step     = byte_vld && (!out_valid || out_ready);
  assign in_ready = !byte_vld || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (in_ready) begin
      byte_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
    end
  end

  tbrp_scope_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .ctrl   (stk),
    .depth  (depth),
    .in_obj (in_obj)
  );

  tbrp_parser #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_NAMES (MAX_NAMES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (byte_q),
    .depth   (depth),
    .in_obj  (in_obj),
    .stk     (stk),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_vld;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      out_q <= res;
    end
  end

  assign kind       = out_q.kind;
  assign value      = out_q.value;
  assign has_name   = out_q.has_name;
  assign name_ref   = out_q.name_ref;
  assign nest_depth = out_q.nest_depth;
  assign run_last   = out_q.run_last;
  assign error_code = out_q.error_code;

`ifndef SYNTHESIS
  a_error_code_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not agree with item kind");

  a_error_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && kind == KIND_ERROR) |=> !out_valid)
    else $error("item offered after an error beat");

  a_run_last_on_runs: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_last) |-> (kind == KIND_PAYLOAD || kind == KIND_NAME))
    else $error("run_last set outside a payload or name run");

  a_name_not_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_name) |-> (kind != KIND_END && kind != KIND_ERROR))
    else $error("field name attached to scope end or error");
`endif

endmodule
